[rtl/text_console_writer_macros.svh]
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Shared assertion forms used by the port checker of the console writer.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define TCW_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("text_console_writer check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define TCW_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("text_console_writer check failed");

`endif

[rtl/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// Text console writer package
// Shared constants, codes and types of the console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int TCW_COLUMNS = 80;
    localparam int TCW_ROWS    = 25;
    localparam int POS_W       = 11;

    localparam logic [7:0]  CHAR_SPACE   = 8'h20;
    localparam logic [7:0]  CHAR_NEWLINE = 8'h0a;
    localparam logic [7:0]  ATTR_FIRST   = 8'h1f;
    localparam logic [15:0] CLEAR_RESET  = 16'h1f20;

    typedef enum logic [1:0] {
        MODE_PUT   = 2'd0,
        MODE_CLEAR = 2'd1,
        MODE_READ  = 2'd2,
        MODE_NOP   = 2'd3
    } tcw_mode_t;

    typedef enum logic [1:0] {
        AOP_PREV,
        AOP_ADV,
        AOP_SHIFT
    } tcw_aop_t;

    typedef struct packed {
        logic [POS_W-1:0] cursor_pos;
        logic [7:0]       cell_char;
        logic [7:0]       cell_attr;
        logic             scrolled;
    } tcw_result_t;

endpackage

[rtl/tcw_ram.sv]
// ----------------------------------------------------------------------------
// Screen cell memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [15:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [15:0]   rd_data
);

    logic [15:0] cells_mem [DEPTH];
    logic [15:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cells_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= cells_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/tcw_addr_unit.sv]
// ----------------------------------------------------------------------------
// Shared address unit
// The one adder that forms the previous cell, the advanced cursor and the
// scroll source address.
// ----------------------------------------------------------------------------
module tcw_addr_unit
    import tcw_pkg::*;
#(
    parameter int COLUMNS = TCW_COLUMNS,
    parameter int AW      = 11
) (
    input  tcw_aop_t      op,
    input  logic [AW-1:0] cursor,
    input  logic [AW-1:0] idx,
    input  logic [AW-1:0] step,
    output logic [AW-1:0] sum
);

    always_comb
    begin
        case (op)
            AOP_PREV:  sum = cursor - AW'(1);
            AOP_ADV:   sum = cursor + step;
            AOP_SHIFT: sum = idx + AW'(COLUMNS);
            default:   sum = cursor;
        endcase
    end

endmodule

[rtl/tcw_ctrl.sv]
// ----------------------------------------------------------------------------
// Console sequencer
// Runs each word through the memory and the shared address unit, and sweeps
// the memory for reset, clear and scroll.
// ----------------------------------------------------------------------------
module tcw_ctrl
    import tcw_pkg::*;
#(
    parameter int COLUMNS = TCW_COLUMNS,
    parameter int ROWS    = TCW_ROWS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [7:0]  char_code,
    input  logic [7:0]  attr,
    input  logic [10:0] cell_index,
    input  logic [15:0] clear_cell,
    input  logic        out_free,
    output logic        push,
    output tcw_result_t result
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);

    localparam logic [AW-1:0] CELLS_LAST     = AW'(CELLS - 1);
    localparam logic [AW-1:0] COPY_LAST      = AW'(CELLS - COLUMNS - 1);
    localparam logic [AW-1:0] LAST_ROW_START = AW'(CELLS - COLUMNS);
    localparam logic [CW-1:0] COL_LAST       = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] ROW_LAST       = RW'(ROWS - 1);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_PUT,
        S_COPY,
        S_DRAIN,
        S_FILL,
        S_READ,
        S_DONE
    } state_t;

    state_t        state_reg, state_next;
    logic [AW-1:0] cursor_reg, cursor_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          copy_pend_reg, copy_pend_next;
    logic [AW-1:0] copy_addr_reg, copy_addr_next;
    logic [7:0]    ch_reg, ch_next;
    logic [7:0]    at_reg, at_next;
    logic          inherit_reg, inherit_next;
    logic          range_reg, range_next;
    logic [7:0]    rd_char_reg, rd_char_next;
    logic [7:0]    rd_attr_reg, rd_attr_next;
    logic          scr_reg, scr_next;

    tcw_aop_t      aop;
    logic [AW-1:0] aop_step;
    logic [AW-1:0] unit_sum;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [15:0]   rd_data;
    logic          in_range;
    logic          newline;
    logic          wrap;
    logic          scroll;
    logic [7:0]    attr_put;

    tcw_addr_unit #(
        .COLUMNS (COLUMNS),
        .AW      (AW)
    ) u_addr (
        .op     (aop),
        .cursor (cursor_reg),
        .idx    (idx_reg),
        .step   (aop_step),
        .sum    (unit_sum)
    );

    tcw_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_range = (32'(cell_index) < 32'(CELLS));
    assign newline  = (ch_reg == CHAR_NEWLINE);
    assign wrap     = newline || (col_reg == COL_LAST);
    assign scroll   = wrap && (row_reg == ROW_LAST);
    assign attr_put = inherit_reg ? rd_data[15:8] : at_reg;
    assign in_stall = (state_reg != S_IDLE);

    assign result.cursor_pos = POS_W'(cursor_reg);
    assign result.cell_char  = rd_char_reg;
    assign result.cell_attr  = rd_attr_reg;
    assign result.scrolled   = scr_reg;

    always_comb
    begin
        state_next     = state_reg;
        cursor_next    = cursor_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        idx_next       = idx_reg;
        copy_pend_next = 1'b0;
        copy_addr_next = copy_addr_reg;
        ch_next        = ch_reg;
        at_next        = at_reg;
        inherit_next   = inherit_reg;
        range_next     = range_reg;
        rd_char_next   = rd_char_reg;
        rd_attr_next   = rd_attr_reg;
        scr_next       = scr_reg;
        aop            = AOP_PREV;
        aop_step       = AW'(1);
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = clear_cell;
        rd_en          = 1'b0;
        rd_addr        = unit_sum;
        push           = 1'b0;

        case (state_reg)
            S_INIT:
            begin
                wr_en    = 1'b1;
                wr_data  = '0;
                idx_next = idx_reg + AW'(1);
                if (idx_reg == CELLS_LAST)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ch_next      = (char_code == 8'd0) ? CHAR_SPACE : char_code;
                    at_next      = (attr != 8'd0) ? attr : ATTR_FIRST;
                    inherit_next = (attr == 8'd0) && (cursor_reg != '0);
                    range_next   = in_range;
                    rd_char_next = '0;
                    rd_attr_next = '0;
                    scr_next     = 1'b0;
                    case (tcw_mode_t'(mode))
                        MODE_PUT:
                        begin
                            rd_en = (attr == 8'd0) && (cursor_reg != '0)
                                    && (char_code != CHAR_NEWLINE);
                            state_next = S_PUT;
                        end
                        MODE_CLEAR:
                        begin
                            cursor_next = '0;
                            col_next    = '0;
                            row_next    = '0;
                            idx_next    = '0;
                            state_next  = S_FILL;
                        end
                        MODE_READ:
                        begin
                            rd_en      = in_range;
                            rd_addr    = AW'(cell_index);
                            state_next = S_READ;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_PUT:
            begin
                aop      = AOP_ADV;
                aop_step = newline ? (AW'(COLUMNS) - AW'(col_reg)) : AW'(1);
                if (!newline)
                begin
                    wr_en   = 1'b1;
                    wr_addr = cursor_reg;
                    wr_data = {attr_put, ch_reg};
                end
                if (scroll)
                begin
                    cursor_next = LAST_ROW_START;
                    col_next    = '0;
                    scr_next    = 1'b1;
                    idx_next    = '0;
                    state_next  = S_COPY;
                end
                else
                begin
                    cursor_next = unit_sum;
                    col_next    = wrap ? '0 : col_reg + CW'(1);
                    row_next    = wrap ? row_reg + RW'(1) : row_reg;
                    state_next  = S_DONE;
                end
            end
            S_COPY:
            begin
                aop            = AOP_SHIFT;
                rd_en          = 1'b1;
                copy_pend_next = 1'b1;
                copy_addr_next = idx_reg;
                idx_next       = idx_reg + AW'(1);
                if (idx_reg == COPY_LAST)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                idx_next   = LAST_ROW_START;
                state_next = S_FILL;
            end
            S_FILL:
            begin
                wr_en    = 1'b1;
                idx_next = idx_reg + AW'(1);
                if (idx_reg == CELLS_LAST)
                begin
                    state_next = S_DONE;
                end
            end
            S_READ:
            begin
                if (range_reg)
                begin
                    rd_char_next = rd_data[7:0];
                    rd_attr_next = rd_data[15:8];
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    push       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (copy_pend_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = copy_addr_reg;
            wr_data = rd_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cursor_reg    <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            idx_reg       <= '0;
            copy_pend_reg <= 1'b0;
            copy_addr_reg <= '0;
            ch_reg        <= '0;
            at_reg        <= '0;
            inherit_reg   <= 1'b0;
            range_reg     <= 1'b0;
            rd_char_reg   <= '0;
            rd_attr_reg   <= '0;
            scr_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            idx_reg       <= idx_next;
            copy_pend_reg <= copy_pend_next;
            copy_addr_reg <= copy_addr_next;
            ch_reg        <= ch_next;
            at_reg        <= at_next;
            inherit_reg   <= inherit_next;
            range_reg     <= range_next;
            rd_char_reg   <= rd_char_next;
            rd_attr_reg   <= rd_attr_next;
            scr_reg       <= scr_next;
        end
    end

endmodule

[rtl/text_console_writer.sv]
// ----------------------------------------------------------------------------
// Text console writer
// Character screen with a cursor: put, clear and read words, one result each.
// ----------------------------------------------------------------------------
// Usage: an input word (mode, char_code, attr, cell_index) is taken when
// in_valid is high and in_stall is low. Each input word yields exactly one
// result word (cursor_pos, cell_char, cell_attr, scrolled), taken when
// out_valid is high and out_stall is low. The user loads the blank cell through
// cfg_wr_en and cfg_wr_data only while idle; the block does not enforce it.
// Flow: one word at a time, since in_stall stays high until the result of the
// last word is pushed. A clear writes the blank cell to all COLUMNS*ROWS cells,
// and a put that scrolls copies the rows up by one and fills the last row, one
// cell copied or filled per cycle.
// Reset: the cursor goes to 0 and a clearing pass writes zero to all
// COLUMNS*ROWS cells, one per cycle; in_stall stays
// high meanwhile, while configuration writes are taken.
// Receiver stall: the result waits in the output register, and the next word
// is accepted and processed; it then holds until the register is free.
// ----------------------------------------------------------------------------
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = TCW_COLUMNS,
    parameter int ROWS    = TCW_ROWS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [7:0]  char_code,
    input  logic [7:0]  attr,
    input  logic [10:0] cell_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [10:0] cursor_pos,
    output logic [7:0]  cell_char,
    output logic [7:0]  cell_attr,
    output logic        scrolled
);

    logic [15:0] clear_cell_reg;
    logic        out_valid_reg;
    tcw_result_t res_reg;
    tcw_result_t result;
    logic        push;
    logic        out_free;

    assign out_free = !out_valid_reg || !out_stall;

    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .char_code  (char_code),
        .attr       (attr),
        .cell_index (cell_index),
        .clear_cell (clear_cell_reg),
        .out_free   (out_free),
        .push       (push),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cell_reg <= CLEAR_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                clear_cell_reg <= cfg_wr_data;
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            res_reg <= result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cursor_pos = res_reg.cursor_pos;
    assign cell_char  = res_reg.cell_char;
    assign cell_attr  = res_reg.cell_attr;
    assign scrolled   = res_reg.scrolled;

endmodule

[rtl/tcw_checker.sv]
// ----------------------------------------------------------------------------
// Text console writer port checker
// Watches the ports of the console writer and flags broken behavior.
// ----------------------------------------------------------------------------
`include "text_console_writer_macros.svh"

module tcw_checker
    import tcw_pkg::*;
#(
    parameter int COLUMNS = TCW_COLUMNS,
    parameter int ROWS    = TCW_ROWS
) (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [10:0] cursor_pos,
    input logic [7:0]  cell_char,
    input logic [7:0]  cell_attr,
    input logic        scrolled
);

    localparam int          CELLS      = COLUMNS * ROWS;
    localparam logic [10:0] SCROLL_POS = 11'((ROWS - 1) * COLUMNS);

    `TCW_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    `TCW_ASSERT_NXT(a_hold_stalled, out_valid && out_stall, out_valid && $stable(cursor_pos) && $stable(cell_char) && $stable(cell_attr) && $stable(scrolled))
    `TCW_ASSERT_IMP(a_scroll_cursor, out_valid && scrolled, cursor_pos == SCROLL_POS)
    `TCW_ASSERT_IMP(a_read_no_scroll, out_valid && (cell_char != 8'd0 || cell_attr != 8'd0), !scrolled)
    `TCW_ASSERT_IMP(a_cursor_range, out_valid, CELLS > 2048 || 32'(cursor_pos) < CELLS)

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cursor_pos (cursor_pos),
    .cell_char  (cell_char),
    .cell_attr  (cell_attr),
    .scrolled   (scrolled)
);

[tb/sv/text_console_writer_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer testbench
// Sends put, clear, read and unused words to the console writer and keeps a
// private copy of the screen, cursor and blank cell to predict every result
// word. Results are checked in order, field by field. Both sides pause at
// random, and the receiver holds off for a long stretch once.
// ----------------------------------------------------------------------------
module text_console_writer_test;
    import tcw_pkg::*;

    localparam int COLS         = TCW_COLUMNS;
    localparam int CELLS        = TCW_COLUMNS * TCW_ROWS;
    localparam int DRAIN_CYCLES = CELLS + 20;
    localparam int LONG_HOLD    = 300;
    localparam int CYCLE_LIMIT  = 8000000;
    localparam int MAX_REPORTS  = 100;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = 16'h0000;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [1:0]  mode        = MODE_NOP;
    logic [7:0]  char_code   = 8'h00;
    logic [7:0]  attr        = 8'h00;
    logic [10:0] cell_index  = 11'd0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [10:0] cursor_pos;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
    logic        scrolled;

    logic [15:0] screen_mem [CELLS];
    int unsigned cursor_at;
    logic [15:0] blank_cell;
    tcw_result_t pending_results [$];

    bit idle_on       = 1'b0;
    int hold_requests = 0;
    int holds_done    = 0;
    int errors        = 0;
    int scrolls_seen  = 0;
    int words_by_mode [4];

    text_console_writer i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .char_code   (char_code),
        .attr        (attr),
        .cell_index  (cell_index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cursor_pos  (cursor_pos),
        .cell_char   (cell_char),
        .cell_attr   (cell_attr),
        .scrolled    (scrolled)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic tcw_result_t apply_console_word(input tcw_mode_t op,
            input logic [7:0] ch, input logic [7:0] at, input logic [10:0] idx);
        tcw_result_t res;
        int unsigned pos;
        logic [7:0]  c;
        logic [7:0]  a;
        res = '0;
        case (op)
            MODE_PUT:
            begin
                pos = cursor_at;
                c = (ch == 8'h00) ? CHAR_SPACE : ch;
                a = at;
                if (a == 8'h00)
                begin
                    if (pos != 0)
                        a = screen_mem[pos - 1][15:8];
                    else
                        a = ATTR_FIRST;
                end
                if (c == CHAR_NEWLINE)
                    pos = pos + COLS - (pos % COLS) - 1;
                else
                    screen_mem[pos] = {a, c};
                pos++;
                if (pos >= CELLS)
                begin
                    for (int i = 0; i < CELLS - COLS; i++)
                        screen_mem[i] = screen_mem[i + COLS];
                    for (int i = CELLS - COLS; i < CELLS; i++)
                        screen_mem[i] = blank_cell;
                    pos = pos - COLS;
                    res.scrolled = 1'b1;
                end
                cursor_at = pos;
            end
            MODE_CLEAR:
            begin
                for (int i = 0; i < CELLS; i++)
                    screen_mem[i] = blank_cell;
                cursor_at = 0;
            end
            MODE_READ:
            begin
                if (idx < CELLS)
                begin
                    res.cell_char = screen_mem[idx][7:0];
                    res.cell_attr = screen_mem[idx][15:8];
                end
            end
            default:
            begin
            end
        endcase
        res.cursor_pos = cursor_at[10:0];
        return res;
    endfunction

    function automatic int idle_len();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    function automatic logic [7:0] pick_char(input int newline_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < newline_pct)
            return CHAR_NEWLINE;
        if (r < newline_pct + 5)
            return 8'h00;
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] pick_attr();
        if ($urandom_range(0, 99) < 25)
            return 8'h00;
        return 8'($urandom);
    endfunction

    function automatic logic [10:0] pick_index();
        if ($urandom_range(0, 9) == 0)
            return 11'($urandom_range(CELLS, 2047));
        return 11'($urandom_range(0, CELLS - 1));
    endfunction

    task automatic send_word(input tcw_mode_t op, input logic [7:0] ch,
            input logic [7:0] at, input logic [10:0] idx);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= op;
        char_code  <= ch;
        attr       <= at;
        cell_index <= idx;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        pending_results.push_back(apply_console_word(op, ch, at, idx));
        words_by_mode[op]++;
    endtask

    task automatic put_char(input logic [7:0] ch, input logic [7:0] at);
        send_word(MODE_PUT, ch, at, 11'($urandom));
    endtask

    task automatic read_cell(input logic [10:0] idx);
        send_word(MODE_READ, 8'($urandom), 8'($urandom), idx);
    endtask

    task automatic clear_screen();
        send_word(MODE_CLEAR, 8'($urandom), 8'($urandom), 11'($urandom));
    endtask

    task automatic write_clear_cell(input logic [15:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        blank_cell = value;
    endtask

    task automatic test_directed();
        read_cell(11'd0);
        put_char(8'h41, 8'h00);
        put_char(8'h00, 8'h4e);
        put_char(8'hff, 8'hff);
        put_char(8'h62, 8'h00);
        put_char(CHAR_NEWLINE, 8'h00);
        put_char(CHAR_NEWLINE, 8'h12);
        put_char(8'h80, 8'h01);
        send_word(MODE_NOP, 8'hff, 8'hff, 11'h7ff);
        for (int i = 0; i < 4; i++)
            read_cell(11'(i));
        read_cell(11'(2 * COLS));
        read_cell(11'(CELLS - 1));
        read_cell(11'(CELLS));
        read_cell(11'h7ff);
        clear_screen();
        read_cell(11'd0);
        read_cell(11'(CELLS - 1));
    endtask

    task automatic test_scroll();
        clear_screen();
        repeat (TCW_ROWS - 1) put_char(CHAR_NEWLINE, pick_attr());
        repeat (COLS - 1) put_char(8'($urandom_range(32, 126)), pick_attr());
        put_char(8'h41, 8'h00);
        read_cell(11'(CELLS - COLS - 1));
        read_cell(11'(CELLS - COLS));
        read_cell(11'(CELLS - 1));
        repeat (COLS - 1) put_char(8'($urandom_range(32, 126)), pick_attr());
        put_char(CHAR_NEWLINE, 8'h00);
        put_char(CHAR_NEWLINE, 8'h5a);
        read_cell(11'(CELLS - 2 * COLS));
        read_cell(11'(CELLS - COLS - 1));
        read_cell(11'(CELLS - 1));
    endtask

    task automatic test_random_text(input int count, input int newline_pct);
        int r;
        clear_screen();
        repeat ($urandom_range(18, 24)) put_char(CHAR_NEWLINE, pick_attr());
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            if (r < 1)
                clear_screen();
            else if (r < 4)
                send_word(MODE_NOP, 8'($urandom), 8'($urandom), 11'($urandom));
            else if (r < 18)
                read_cell(pick_index());
            else
                put_char(pick_char(newline_pct), pick_attr());
        end
    endtask

    task automatic test_long_hold();
        idle_on = 1'b0;
        hold_requests++;
        repeat (30)
        begin
            if ($urandom_range(0, 3) == 0)
                read_cell(pick_index());
            else
                put_char(pick_char(10), pick_attr());
        end
        idle_on = 1'b1;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
            input logic [15:0] got);
        if (got !== want)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
        end
    endtask

    initial
    begin : receiver
        int stall_left;
        int run_left;
        stall_left = 0;
        run_left = 0;
        forever
        begin
            @(posedge clk);
            if (holds_done != hold_requests)
            begin
                holds_done = hold_requests;
                stall_left = LONG_HOLD;
            end
            else if (stall_left == 0 && run_left == 0)
            begin
                stall_left = idle_len();
                run_left = $urandom_range(1, 12);
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                if (run_left > 0)
                    run_left--;
            end
        end
    end

    initial
    begin : result_checker
        tcw_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (pending_results.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: unexpected result word, expected none, actual cursor %0d",
                                 $time, cursor_pos);
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("cursor_pos", 16'(want.cursor_pos), 16'(cursor_pos));
                    check_field("cell_char", 16'(want.cell_char), 16'(cell_char));
                    check_field("cell_attr", 16'(want.cell_attr), 16'(cell_attr));
                    check_field("scrolled", 16'(want.scrolled), 16'(scrolled));
                    if (scrolled === 1'b1)
                        scrolls_seen++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < CELLS; i++)
            screen_mem[i] = 16'h0000;
        cursor_at = 0;
        blank_cell = CLEAR_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        write_clear_cell(16'hffff);
        idle_on = 1'b1;
        test_scroll();
        write_clear_cell(16'h0000);
        test_random_text(150, 12);
        write_clear_cell(16'($urandom));
        idle_on = 1'b0;
        test_random_text(150, 4);
        idle_on = 1'b1;
        write_clear_cell(16'($urandom));
        test_random_text(150, 8);
        test_long_hold();

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d puts, %0d clears, %0d reads and %0d unused words",
                 words_by_mode[MODE_PUT], words_by_mode[MODE_CLEAR],
                 words_by_mode[MODE_READ], words_by_mode[MODE_NOP]);
        $display("with %0d scrolls, 4 blank cell settings and %0d long receiver hold; %0d errors",
                 scrolls_seen, holds_done, errors);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/tcw_addr_unit.sv
rtl/tcw_ctrl.sv
rtl/text_console_writer.sv
rtl/tcw_checker.sv
tb/sv/text_console_writer_test.sv
